### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the design, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// shared widths, register indexes and defaults of the 3x3 filter core
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int unsigned C3F_MAX_WIDTH = 1024;
  localparam int unsigned C3F_COEF_BITS = 8;
  localparam int unsigned KERNEL_SIZE   = 3;
  localparam int unsigned NUM_TAPS      = KERNEL_SIZE * KERNEL_SIZE;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned BIAS_W  = 11;
  localparam int unsigned IW_W    = 11;
  localparam int unsigned IH_W    = 13;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned WCMP_W  = 13;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIV_STEPS = 17;

  typedef enum logic [CIDX_W-1:0] {
    REG_KTOP  = 3'd0,
    REG_KMID  = 3'd1,
    REG_KBOT  = 3'd2,
    REG_SCALE = 3'd3,
    REG_BIAS  = 3'd4,
    REG_WIDTH = 3'd5,
    REG_HEIGHT = 3'd6
  } c3f_reg_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic lft_ok;
    logic rgt_ok;
  } c3f_edge_t;

endpackage

### design/c3f_in_if.sv
// ----------------------------------------------------------------------------
// c3f_in_if
// pixel input channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface c3f_in_if import c3f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             drain;

  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

### design/c3f_out_if.sv
// ----------------------------------------------------------------------------
// c3f_out_if
// filtered pixel output channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface c3f_out_if import c3f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

### design/c3f_cfg_if.sv
// ----------------------------------------------------------------------------
// c3f_cfg_if
// register write channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface c3f_cfg_if import c3f_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/conv3x3_image_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core
// 3x3 signed correlation filter over a raster pixel stream, scaled and clamped
// ----------------------------------------------------------------------------
// a result reaches the output register, through the stages below, after the
//   transaction that completes its window (one row plus one pixel later in the stream)
// throughput: one input transaction per cycle, set by the six-stage pipeline and
//   a line memory read and written once per cycle, unless out_ch stalls
// reset (synchronous, rst_n low) clears counters, valids and configuration registers
//   to their defaults; the kernel reciprocal is then recomputed, and again after
//   every register write, with in_ch.ready held low meanwhile
`include "assert_macros.svh"

module conv3x3_image_filter_core import c3f_pkg::*; #(
  parameter int unsigned MAX_WIDTH = C3F_MAX_WIDTH,
  parameter int unsigned COEF_BITS = C3F_COEF_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  c3f_in_if.sink    in_ch,
  c3f_out_if.source out_ch,
  c3f_cfg_if.sink   cfg_ch
);

  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH + 1);
  localparam logic signed [45:0] CLAMP_HI = 46'sd16711680;

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]         krow_r [KERNEL_SIZE];
  logic signed [CFG_W-1:0]  scale_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic [IW_W-1:0]          iw_r;
  logic [IH_W-1:0]          ih_r;
  logic                     cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r[0] <= '0;
      krow_r[1] <= CFG_W'(256);
      krow_r[2] <= '0;
      scale_r   <= '0;
      bias_r    <= '0;
      iw_r      <= IW_W'(1024);
      ih_r      <= IH_W'(1024);
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_KTOP:   krow_r[0] <= cfg_ch.data;
        REG_KMID:   krow_r[1] <= cfg_ch.data;
        REG_KBOT:   krow_r[2] <= cfg_ch.data;
        REG_SCALE:  scale_r   <= cfg_ch.data;
        REG_BIAS:   bias_r    <= cfg_ch.data[BIAS_W-1:0];
        REG_WIDTH:  iw_r      <= cfg_ch.data[IW_W-1:0];
        REG_HEIGHT: ih_r      <= cfg_ch.data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // taps: low COEF_BITS of each byte, sign extended
  logic signed [PIX_W-1:0]     tap_w [NUM_TAPS];
  logic signed [COEF_BITS-1:0] coef_w [NUM_TAPS];
  logic signed [11:0]          tap_sum;

  always_comb begin
    tap_sum = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        coef_w[r*3+c] = krow_r[r][8*c +: COEF_BITS];
        tap_w[r*3+c]  = PIX_W'(coef_w[r*3+c]);
      end
    end
    for (int i = 0; i < NUM_TAPS; i++) begin
      tap_sum = tap_sum + 12'(tap_w[i]);
    end
  end

  // effective geometry
  logic [WCMP_W-1:0] w13;
  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;

  always_comb begin
    if (iw_r == '0) begin
      w13 = WCMP_W'(1);
    end else if (WCMP_W'(iw_r) > WCMP_W'(MAX_WIDTH)) begin
      w13 = WCMP_W'(MAX_WIDTH);
    end else begin
      w13 = WCMP_W'(iw_r);
    end
    w_eff = w13[COL_W-1:0];
    h_eff = (ih_r == '0) ? ROW_W'(1) : ROW_W'(ih_r);
  end

  // --------------------------------------------------------------------------
  // factor unit: nonzero scale, else 65536 / kernel sum (65536 if zero), one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic                    start_r, busy_r, neg_r, zero_r;
  logic [10:0]             den_r, rem_r;
  logic [DIV_STEPS-1:0]    quot_r;
  logic [4:0]              cnt_r;
  logic signed [CFG_W-1:0] factor_r;
  logic [11:0]             trial;
  logic                    qbit;
  logic [DIV_STEPS-1:0]    quot_nxt;
  logic                    div_busy;

  assign div_busy = start_r || busy_r;
  assign trial    = {rem_r, (cnt_r == 5'(DIV_STEPS - 1))};
  assign qbit     = (trial >= {1'b0, den_r});
  assign quot_nxt = {quot_r[DIV_STEPS-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        start_r <= 1'b1;
      end else if (start_r) begin
        start_r <= 1'b0;
      end
      if (start_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      den_r  <= (tap_sum < 0) ? 11'(-tap_sum) : 11'(tap_sum);
      neg_r  <= (tap_sum < 0);
      zero_r <= (tap_sum == '0);
      rem_r  <= '0;
      quot_r <= '0;
      cnt_r  <= 5'(DIV_STEPS - 1);
    end else if (busy_r) begin
      rem_r  <= qbit ? 11'(trial - {1'b0, den_r}) : trial[10:0];
      quot_r <= quot_nxt;
      cnt_r  <= cnt_r - 5'd1;
      if (cnt_r == '0) begin
        if (scale_r != '0) begin
          factor_r <= scale_r;
        end else if (zero_r) begin
          factor_r <= CFG_W'(1 << FRAC_W);
        end else if (neg_r) begin
          factor_r <= -$signed(CFG_W'(quot_nxt));
        end else begin
          factor_r <= $signed(CFG_W'(quot_nxt));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage enables: a stage takes new data when empty or when it moves on
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;
  logic adv1, in_fire;

  assign en6  = !v6_r || out_ch.ready;
  assign en5  = !v5_r || en6;
  assign en4  = !v4_r || en5;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign adv1 = v1_r && en2;

  assign in_ch.ready = en1 && !div_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // stage 1: frame position, window edges, line memory access
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, c1, c2, ocol;
  logic [ROW_W-1:0] row_r, r1, r2, orow;
  logic             flushing, drop, have, last, latch_en;
  logic [PIX_W-1:0] pix_new;
  logic [IDX_W-1:0] x_new;
  c3f_edge_t        edge_new;
  logic signed [CFG_W-1:0] eff_r;

  always_comb begin
    c1 = col_r;
    r1 = row_r;
    if (col_r >= w_eff) begin
      c1 = '0;
      r1 = row_r + ROW_W'(1);
    end
    if (r1 > h_eff + ROW_W'(1)) begin
      c1 = '0;
      r1 = '0;
    end
    flushing = (r1 >= h_eff);
    drop     = !flushing && in_ch.drain;
    latch_en = in_fire && !drop && (r1 == '0) && (c1 == '0);
    pix_new  = flushing ? '0 : in_ch.pixel_in;
    x_new    = c1[IDX_W-1:0];

    have = 1'b0;
    orow = '0;
    ocol = '0;
    if (c1 != '0 && r1 != '0) begin
      have = 1'b1;
      orow = r1 - ROW_W'(1);
      ocol = c1 - COL_W'(1);
    end else if (c1 == '0 && r1 >= ROW_W'(2)) begin
      have = 1'b1;
      orow = r1 - ROW_W'(2);
      ocol = w_eff - COL_W'(1);
    end

    edge_new.top_ok = (orow != '0);
    edge_new.bot_ok = (orow + ROW_W'(1) < h_eff);
    edge_new.lft_ok = (ocol != '0);
    edge_new.rgt_ok = ((COL_W+1)'(ocol) + (COL_W+1)'(1) < (COL_W+1)'(w_eff));
    last = have && !edge_new.bot_ok && !edge_new.rgt_ok;

    // position of the next transaction
    c2 = c1 + COL_W'(1);
    r2 = r1;
    if (c2 >= w_eff) begin
      c2 = '0;
      r2 = r1 + ROW_W'(1);
    end
    if (last) begin
      c2 = '0;
      r2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      eff_r <= '0;
    end else if (in_fire) begin
      // a drain before the frame's pixels are in still settles the wrap
      col_r <= drop ? c1 : c2;
      row_r <= drop ? r1 : r2;
      if (latch_en) begin
        eff_r <= factor_r;
      end
    end
  end

  // line memory holds {row above, current row} per column
  logic [2*PIX_W-1:0] line_mem_r [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd1_r;
  logic [IDX_W-1:0]   x1_r;
  logic [PIX_W-1:0]   p1_r;
  logic               have1_r, last1_r;
  c3f_edge_t          edge1_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      line_mem_r[x1_r] <= {rd1_r[PIX_W-1:0], p1_r};
    end
    if (in_fire && !drop) begin
      // the write above lands at this edge, so forward it on a same-column hit
      if (adv1 && x1_r == x_new) begin
        rd1_r <= {rd1_r[PIX_W-1:0], p1_r};
      end else begin
        rd1_r <= line_mem_r[x_new];
      end
      x1_r    <= x_new;
      p1_r    <= pix_new;
      have1_r <= have;
      last1_r <= last;
      edge1_r <= edge_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_fire && !drop;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: 3x3 window, shifted for every transaction in stream order
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] win_r [NUM_TAPS];
  c3f_edge_t        edge2_r;
  logic             last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        win_r[i] <= '0;
      end
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= rd1_r[2*PIX_W-1:PIX_W];
        win_r[5] <= rd1_r[PIX_W-1:0];
        win_r[8] <= p1_r;
      end
      if (en2) begin
        v2_r <= adv1 && have1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      edge2_r <= edge1_r;
      last2_r <= last1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: edge replacement by the centre pixel and tap products
  // --------------------------------------------------------------------------
  logic signed [16:0] prod3_r [NUM_TAPS];
  logic signed [16:0] prod_w  [NUM_TAPS];
  logic               last3_r;
  logic [2:0]         row_ok, col_ok;

  always_comb begin
    row_ok = {edge2_r.bot_ok, 1'b1, edge2_r.top_ok};
    col_ok = {edge2_r.rgt_ok, 1'b1, edge2_r.lft_ok};
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        prod_w[r*3+c] = tap_w[r*3+c] * $signed({1'b0,
          (row_ok[r] && col_ok[c]) ? win_r[r*3+c] : win_r[4]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        prod3_r[i] <= prod_w[i];
      end
      last3_r <= last2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: tap sum
  // --------------------------------------------------------------------------
  logic signed [20:0] sum_w, sum4_r;
  logic               last4_r;

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      sum_w = sum_w + 21'(prod3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      sum4_r  <= sum_w;
      last4_r <= last3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: Q8.16 scaling
  // --------------------------------------------------------------------------
  logic signed [44:0] mul5_r;
  logic               last5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      mul5_r  <= eff_r * sum4_r;
      last5_r <= last4_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: bias, floor to integer, clamp to 0..255; output register
  // --------------------------------------------------------------------------
  logic signed [45:0] biased;
  logic [PIX_W-1:0]   pix_w, pix6_r;
  logic               last6_r;

  always_comb begin
    biased = 46'(mul5_r) + (46'(bias_r) <<< FRAC_W);
    if (biased > CLAMP_HI) begin
      pix_w = '1;
    end else if (biased < 0) begin
      pix_w = '0;
    end else begin
      pix_w = biased[FRAC_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && v5_r) begin
      pix6_r  <= pix_w;
      last6_r <= last5_r;
    end
  end

  assign out_ch.valid      = v6_r;
  assign out_ch.pixel_out  = pix6_r;
  assign out_ch.last_pixel = last6_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // the reciprocal is never half done when a pixel enters
  `ASSERT_IMPLIES(a_no_pix_busy, clk, rst_n, div_busy, !in_fire)
  // a latched frame factor is never zero
  `ASSERT_NEXT(a_factor_set, clk, rst_n, latch_en, eff_r != '0)
  // the window stage only fills from a stage 1 move
  `ASSERT_IMPLIES(a_s2_src, clk, rst_n, $rose(v2_r), $past(adv1))

endmodule
